@@ hw/rtl/hcd_pkg.sv @@
// Shared constants, types and the CRC-16/ARC byte update for the packet deframer.
package hcd_pkg;

  localparam int PACKET_BYTES_DEF   = 24;
  localparam int CRC_SPAN_BYTES_DEF = 22;

  // field widths on the item channels
  localparam int IDX_W   = 5;
  localparam int COUNT_W = 5;

  localparam logic [7:0]  HDR_FIRST     = 8'hAA;
  localparam logic [7:0]  HDR_SECOND    = 8'hCC;
  localparam logic [15:0] CRC_REFL_POLY = 16'hA001;

  // operation codes
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // status codes
  localparam logic [3:0] ST_IGNORED  = 4'd0;
  localparam logic [3:0] ST_HEADER   = 4'd1;
  localparam logic [3:0] ST_MISMATCH = 4'd2;
  localparam logic [3:0] ST_BODY     = 4'd3;
  localparam logic [3:0] ST_ACCEPT   = 4'd4;
  localparam logic [3:0] ST_CRC_FAIL = 4'd5;
  localparam logic [3:0] ST_DROPPED  = 4'd6;
  localparam logic [3:0] ST_RELEASED = 4'd7;
  localparam logic [3:0] ST_READ     = 4'd8;

  typedef struct packed {
    logic [3:0] status;
    logic       packet_ready;
  } hcd_res_t;

  // reflected CRC-16, poly 0x8005, one byte per call
  function automatic logic [15:0] crc_arc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_REFL_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/hcd_in_if.sv @@
// Input item channel: operation, received byte and read position.
interface hcd_in_if import hcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [7:0]       rx_byte;
  logic [IDX_W-1:0] read_index;

  modport source (output valid, operation, rx_byte, read_index, input ready);
  modport sink   (input valid, operation, rx_byte, read_index, output ready);
endinterface

@@ hw/rtl/hcd_out_if.sv @@
// Result item channel: status, held flag, stored byte count and read data.
interface hcd_out_if import hcd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [3:0]         status;
  logic               packet_ready;
  logic [COUNT_W-1:0] byte_count;
  logic [7:0]         read_value;

  modport source (output valid, status, packet_ready, byte_count, read_value, input ready);
  modport sink   (input valid, status, packet_ready, byte_count, read_value, output ready);
endinterface

@@ hw/rtl/hcd_cfg_if.sv @@
// Configuration write channel carrying the CRC check enable bit.
interface hcd_cfg_if;
  logic valid;
  logic ready;
  logic crc_check_enable;

  modport source (output valid, crc_check_enable, input ready);
  modport sink   (input valid, crc_check_enable, output ready);
endinterface

@@ hw/rtl/hcd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hcd_ram #(
  parameter int Width = 8,
  parameter int Depth = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ hw/rtl/hcd_core.sv @@
// Deframer state: header hunt, byte count, running CRC and packet check.
module hcd_core import hcd_pkg::*; #(
  parameter int PACKET_BYTES   = PACKET_BYTES_DEF,
  parameter int CRC_SPAN_BYTES = CRC_SPAN_BYTES_DEF,
  localparam int AddrW  = $clog2(PACKET_BYTES),
  localparam int CountW = $clog2(PACKET_BYTES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [1:0]        op_i,
  input  logic [7:0]        byte_i,
  input  logic              crc_en_i,
  output logic              we_o,
  output logic [AddrW-1:0]  waddr_o,
  output logic [7:0]        wdata_o,
  output hcd_res_t          res_o,
  output logic [CountW-1:0] count_o
);
  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_AWAIT = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;

  logic [1:0]        phase_q, phase_d;
  logic              held_q, held_d;
  logic [CountW-1:0] count_q, count_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        crc_hi_q, crc_hi_d;
  logic [3:0]        status;

  // storing at base_count (count_q, or zero on a first header byte): write, advance CRC over the span, count up
  logic [CountW-1:0] base_count;
  logic [15:0]       base_crc;
  logic              do_store;
  logic              room;
  logic [15:0]       crc_after;
  logic [CountW-1:0] count_after;

  always_comb begin
    room        = int'(base_count) < PACKET_BYTES;
    crc_after   = (int'(base_count) < CRC_SPAN_BYTES) ? crc_arc_byte(base_crc, byte_i)
                                                      : base_crc;
    count_after = base_count + CountW'(1);
  end

  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    count_d    = count_q;
    crc_d      = crc_q;
    crc_hi_d   = crc_hi_q;
    status     = ST_IGNORED;
    base_count = count_q;
    base_crc   = crc_q;
    do_store   = 1'b0;

    case (op_i)
      OP_BYTE: begin
        if (held_q) begin
          status = ST_DROPPED;
        end else begin
          case (phase_q)
            PH_HUNT: begin
              if (byte_i == HDR_FIRST) begin
                base_count = '0;
                base_crc   = '0;
                do_store   = 1'b1;
                phase_d    = PH_AWAIT;
                status     = ST_HEADER;
              end
            end
            PH_AWAIT: begin
              if (byte_i == HDR_SECOND) begin
                do_store = 1'b1;
                phase_d  = PH_BODY;
                status   = ST_HEADER;
              end else begin
                phase_d = PH_HUNT;
                count_d = '0;
                crc_d   = '0;
                status  = ST_MISMATCH;
              end
            end
            default: begin
              do_store = 1'b1;
              if (int'(count_after) < PACKET_BYTES) begin
                status = ST_BODY;
              end else if (!crc_en_i ||
                           (crc_hi_q == crc_after[15:8] && byte_i == crc_after[7:0])) begin
                held_d = 1'b1;
                status = ST_ACCEPT;
              end else begin
                do_store = 1'b0;
                phase_d  = PH_HUNT;
                count_d  = '0;
                crc_d    = '0;
                status   = ST_CRC_FAIL;
              end
            end
          endcase
        end
      end
      OP_RELEASE: begin
        if (held_q) begin
          held_d  = 1'b0;
          phase_d = PH_HUNT;
          count_d = '0;
          crc_d   = '0;
        end
        status = ST_RELEASED;
      end
      OP_READ: begin
        status = ST_READ;
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase

    if (do_store && room) begin
      count_d = count_after;
      crc_d   = crc_after;
      if (int'(base_count) == PACKET_BYTES - 2) begin
        crc_hi_d = byte_i;
      end
    end
  end

  // the failed last byte is still written, like the accepted one
  assign we_o    = fire_i && room && (do_store || status == ST_CRC_FAIL);
  assign waddr_o = base_count[AddrW-1:0];
  assign wdata_o = byte_i;

  assign res_o.status       = status;
  assign res_o.packet_ready = held_d;
  assign count_o            = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      held_q   <= 1'b0;
      count_q  <= '0;
      crc_q    <= '0;
      crc_hi_q <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      held_q   <= held_d;
      count_q  <= count_d;
      crc_q    <= crc_d;
      crc_hi_q <= crc_hi_d;
    end
  end
endmodule

@@ hw/rtl/header_crc_packet_deframer.sv @@
// Header-hunting packet deframer with CRC-16/ARC check, top level.
//
// Takes one input item per clock cycle unless results stall, and returns one
// result per item via the input register, then the result register with the
// packet RAM's registered read beside it. Unstalled, throughput is one item per
// cycle, set by the core's combinational byte-wide CRC update; a stalled result
// holds the pipeline, while the input register still takes one more item.
// Packet bytes live in a PACKET_BYTES x 8 RAM that is not cleared at reset, so
// reads of positions not written since reset return undefined data. Reads at
// or past PACKET_BYTES return zero. The CRC check enable is written over its
// own channel, which is always ready, and should only change while idle.
module header_crc_packet_deframer import hcd_pkg::*; #(
  parameter int PACKET_BYTES   = PACKET_BYTES_DEF,
  parameter int CRC_SPAN_BYTES = CRC_SPAN_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hcd_in_if.sink    in_i,
  hcd_out_if.source out_o,
  hcd_cfg_if.sink   cfg_i
);
  localparam int AddrW  = $clog2(PACKET_BYTES);
  localparam int CountW = $clog2(PACKET_BYTES + 1);

  logic crc_en_q;

  logic             in_valid_q;
  logic [1:0]       op_q;
  logic [7:0]       byte_q;
  logic [IDX_W-1:0] idx_q;

  logic              out_valid_q;
  hcd_res_t          res_q;
  logic [CountW-1:0] count_q;
  logic              rd_ok_q;

  logic              advance, fire, in_xfer;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [7:0]        wdata, rdata;
  hcd_res_t          res;
  logic [CountW-1:0] count;
  logic              rd_ok;

  assign advance = !out_valid_q || out_o.ready;
  assign fire    = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;
  assign in_xfer = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign rd_ok = (op_q == OP_READ) && (int'(idx_q) < PACKET_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_en_q <= 1'b1;
    end else if (cfg_i.valid) begin
      crc_en_q <= cfg_i.crc_check_enable;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= in_i.operation;
      byte_q <= in_i.rx_byte;
      idx_q  <= in_i.read_index;
    end
    if (fire) begin
      res_q   <= res;
      count_q <= count;
      rd_ok_q <= rd_ok;
    end
  end

  hcd_core #(
    .PACKET_BYTES  (PACKET_BYTES),
    .CRC_SPAN_BYTES(CRC_SPAN_BYTES)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .op_i    (op_q),
    .byte_i  (byte_q),
    .crc_en_i(crc_en_q),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .res_o   (res),
    .count_o (count)
  );

  hcd_ram #(
    .Width(8),
    .Depth(PACKET_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (fire),
    .raddr_i(AddrW'(idx_q)),
    .rdata_o(rdata)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = res_q.status;
  assign out_o.packet_ready = res_q.packet_ready;
  assign out_o.byte_count   = COUNT_W'(count_q);
  assign out_o.read_value   = rd_ok_q ? rdata : 8'h00;
endmodule

@@ hw/rtl/hcd_checker.sv @@
// Port-level assertions for the packet deframer, bound to the top level.
module hcd_checker import hcd_pkg::*; #(
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         status,
  input logic               packet_ready,
  input logic [COUNT_W-1:0] byte_count,
  input logic [7:0]         read_value
);
  // a stalled result transfer keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(packet_ready) &&
      $stable(byte_count) && $stable(read_value))
    else $error("result changed while stalled");

  // a held packet is always complete
  a_held_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && packet_ready |-> byte_count == COUNT_W'(PACKET_BYTES))
    else $error("packet held with wrong byte count");

  a_accept_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status == ST_ACCEPT || status == ST_DROPPED) |-> packet_ready)
    else $error("accept or drop without held packet");

  a_release_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status == ST_RELEASED || status == ST_CRC_FAIL ||
                  status == ST_MISMATCH) |-> !packet_ready)
    else $error("packet still held after release or restart");

  a_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status != ST_READ |-> read_value == 8'h00)
    else $error("read data on a non-read result");
endmodule

bind header_crc_packet_deframer hcd_checker #(
  .PACKET_BYTES(PACKET_BYTES)
) u_hcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .status      (out_o.status),
  .packet_ready(out_o.packet_ready),
  .byte_count  (out_o.byte_count),
  .read_value  (out_o.read_value)
);

@@ dv/tb_header_crc_packet_deframer.sv @@
// Self-checking testbench for the header-hunting CRC-16/ARC packet deframer.
module tb_header_crc_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import hcd_pkg::*;

  localparam int PKT_LEN = PACKET_BYTES_DEF;
  localparam int CRC_SPAN = CRC_SPAN_BYTES_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_PER_SETTING = 280;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef enum logic [1:0] {HUNT_AA, HUNT_CC, IN_BODY} hunt_phase_e;
  typedef enum logic [1:0] {ROW_ITEM, ROW_GOOD_PKT, ROW_BAD_PKT} row_kind_e;

  typedef struct packed {
    logic [3:0] status;
    logic       pkt_ready;
    logic [4:0] count;
    logic [7:0] rdata;
  } deframe_res_t;

  typedef struct packed {
    row_kind_e    kind;
    logic [1:0]   op;
    logic [7:0]   b;
    logic [4:0]   idx;
    logic         pinned;
    deframe_res_t want;
  } stim_row_t;

  localparam deframe_res_t NOTHING_PINNED = '0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hcd_in_if  in_if ();
  hcd_out_if out_if ();
  hcd_cfg_if cfg_if ();

  header_crc_packet_deframer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  hunt_phase_e hunt_phase;
  logic        pkt_held;
  logic [4:0]  n_stored;
  logic [15:0] crc_acc;
  logic [7:0]  pkt_mem [PKT_LEN];
  bit          mem_valid [PKT_LEN];
  logic        chk_en;

  deframe_res_t expected_results [$];
  int unsigned  mismatches = 0;
  int unsigned  results_seen = 0;
  int unsigned  items_sent = 0;
  int unsigned  cycle_count = 0;
  int unsigned  no_gap_left = 0;
  bit           long_hold_done = 1'b0;

  // directed items; expectations typed in where obvious, the rest predicted
  stim_row_t directed_rows [0:22] = '{
    '{ROW_ITEM, OP_UNUSED,  8'hFF, 5'd31, 1'b1, '{ST_IGNORED,  1'b0, 5'd0,  8'h00}},
    '{ROW_ITEM, OP_BYTE,    8'h00, 5'd0,  1'b1, '{ST_IGNORED,  1'b0, 5'd0,  8'h00}},
    '{ROW_ITEM, OP_RELEASE, 8'h00, 5'd0,  1'b1, '{ST_RELEASED, 1'b0, 5'd0,  8'h00}},
    '{ROW_ITEM, OP_READ,    8'h00, 5'd31, 1'b1, '{ST_READ,     1'b0, 5'd0,  8'h00}},
    '{ROW_ITEM, OP_READ,    8'hFF, 5'd24, 1'b1, '{ST_READ,     1'b0, 5'd0,  8'h00}},
    '{ROW_ITEM, OP_BYTE,    8'hAA, 5'd0,  1'b1, '{ST_HEADER,   1'b0, 5'd1,  8'h00}},
    '{ROW_ITEM, OP_BYTE,    8'h55, 5'd0,  1'b1, '{ST_MISMATCH, 1'b0, 5'd0,  8'h00}},
    // a dropped mismatch byte is not taken as a new first header byte
    '{ROW_ITEM, OP_BYTE,    8'hCC, 5'd0,  1'b1, '{ST_IGNORED,  1'b0, 5'd0,  8'h00}},
    '{ROW_ITEM, OP_BYTE,    8'hAA, 5'd0,  1'b1, '{ST_HEADER,   1'b0, 5'd1,  8'h00}},
    '{ROW_ITEM, OP_BYTE,    8'hAA, 5'd0,  1'b1, '{ST_MISMATCH, 1'b0, 5'd0,  8'h00}},
    '{ROW_GOOD_PKT, OP_BYTE, 8'h00, 5'd0, 1'b0, NOTHING_PINNED},
    '{ROW_ITEM, OP_BYTE,    8'h00, 5'd0,  1'b1, '{ST_DROPPED,  1'b1, 5'd24, 8'h00}},
    '{ROW_ITEM, OP_BYTE,    8'hAA, 5'd0,  1'b1, '{ST_DROPPED,  1'b1, 5'd24, 8'h00}},
    '{ROW_ITEM, OP_READ,    8'h00, 5'd0,  1'b1, '{ST_READ,     1'b1, 5'd24, 8'hAA}},
    '{ROW_ITEM, OP_READ,    8'h00, 5'd1,  1'b1, '{ST_READ,     1'b1, 5'd24, 8'hCC}},
    '{ROW_ITEM, OP_READ,    8'h00, 5'd23, 1'b0, NOTHING_PINNED},
    '{ROW_ITEM, OP_READ,    8'h00, 5'd31, 1'b1, '{ST_READ,     1'b1, 5'd24, 8'h00}},
    '{ROW_ITEM, OP_UNUSED,  8'h00, 5'd0,  1'b1, '{ST_IGNORED,  1'b1, 5'd24, 8'h00}},
    '{ROW_ITEM, OP_RELEASE, 8'h00, 5'd0,  1'b1, '{ST_RELEASED, 1'b0, 5'd0,  8'h00}},
    '{ROW_ITEM, OP_RELEASE, 8'h00, 5'd0,  1'b1, '{ST_RELEASED, 1'b0, 5'd0,  8'h00}},
    '{ROW_BAD_PKT, OP_BYTE, 8'h00, 5'd0,  1'b0, NOTHING_PINNED},
    '{ROW_ITEM, OP_READ,    8'h00, 5'd5,  1'b0, NOTHING_PINNED},
    '{ROW_ITEM, OP_BYTE,    8'hCC, 5'd0,  1'b1, '{ST_IGNORED,  1'b0, 5'd0,  8'h00}}
  };

  bit crc_plan [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  // bitwise reflected form: feed one data bit per shift
  function automatic logic [15:0] crc16_arc_update(logic [15:0] acc, logic [7:0] data);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ data[k]) begin
        r = {1'b0, r[15:1]} ^ CRC_REFL_POLY;
      end else begin
        r = {1'b0, r[15:1]};
      end
    end
    return r;
  endfunction

  function automatic void clear_hunt();
    hunt_phase = HUNT_AA;
    n_stored = '0;
    crc_acc = '0;
  endfunction

  function automatic void stash(logic [7:0] b);
    if (n_stored < PKT_LEN) begin
      pkt_mem[n_stored] = b;
      mem_valid[n_stored] = 1'b1;
      if (n_stored < CRC_SPAN) crc_acc = crc16_arc_update(crc_acc, b);
      n_stored++;
    end
  endfunction

  function automatic logic [3:0] absorb_byte(logic [7:0] b);
    if (pkt_held) return ST_DROPPED;
    case (hunt_phase)
      HUNT_AA: begin
        if (b != HDR_FIRST) return ST_IGNORED;
        clear_hunt();
        stash(b);
        hunt_phase = HUNT_CC;
        return ST_HEADER;
      end
      HUNT_CC: begin
        if (b != HDR_SECOND) begin
          clear_hunt();
          return ST_MISMATCH;
        end
        stash(b);
        hunt_phase = IN_BODY;
        return ST_HEADER;
      end
      default: ;
    endcase
    stash(b);
    if (n_stored < PKT_LEN) return ST_BODY;
    if (!chk_en || (pkt_mem[PKT_LEN-2] == crc_acc[15:8] &&
                    pkt_mem[PKT_LEN-1] == crc_acc[7:0])) begin
      pkt_held = 1'b1;
      return ST_ACCEPT;
    end
    clear_hunt();
    return ST_CRC_FAIL;
  endfunction

  function automatic deframe_res_t predict_item(logic [1:0] op, logic [7:0] b,
                                                logic [4:0] idx);
    deframe_res_t r;
    r.status = ST_IGNORED;
    r.rdata = '0;
    case (op)
      OP_BYTE: r.status = absorb_byte(b);
      OP_RELEASE: begin
        if (pkt_held) begin
          pkt_held = 1'b0;
          clear_hunt();
        end
        r.status = ST_RELEASED;
      end
      OP_READ: begin
        if (idx < PKT_LEN) r.rdata = pkt_mem[idx];
        r.status = ST_READ;
      end
      default: ;
    endcase
    r.pkt_ready = pkt_held;
    r.count = n_stored;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] MISMATCH result %0d: %s", $time, results_seen, msg);
  endtask

  // mostly back to back, sometimes short or long gaps, now and then a gapless run
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      no_gap_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [7:0] noise_byte();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return HDR_FIRST;
    if (roll < 5) return HDR_SECOND;
    return 8'($urandom);
  endfunction

  // never point at a store entry that has not been written since reset
  function automatic logic [4:0] pick_read_index();
    logic [4:0] idx;
    idx = 5'($urandom_range(0, 31));
    if (idx < PKT_LEN && !mem_valid[idx]) idx = 5'(PKT_LEN + $urandom_range(0, 31 - PKT_LEN));
    return idx;
  endfunction

  task automatic send_item(logic [1:0] op, logic [7:0] b, logic [4:0] idx,
                           logic pinned = 1'b0, deframe_res_t want = '0);
    int unsigned gap;
    deframe_res_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.rx_byte <= b;
    in_if.read_index <= idx;
    do @(posedge clk_i); while (!in_if.ready);
    r = predict_item(op, b, idx);
    expected_results.push_back(pinned ? want : r);
    items_sent++;
  endtask

  task automatic send_frame(bit corrupt);
    logic [7:0]  pkt [PKT_LEN];
    logic [15:0] crc;
    int unsigned pos;
    crc = '0;
    pkt[0] = HDR_FIRST;
    pkt[1] = HDR_SECOND;
    for (int i = 2; i < PKT_LEN - 2; i++) pkt[i] = 8'($urandom);
    for (int i = 0; i < CRC_SPAN; i++) crc = crc16_arc_update(crc, pkt[i]);
    pkt[PKT_LEN-2] = crc[15:8];
    pkt[PKT_LEN-1] = crc[7:0];
    if (corrupt) begin
      pos = $urandom_range(2, PKT_LEN - 1);
      pkt[pos] = pkt[pos] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < PKT_LEN; i++) send_item(OP_BYTE, pkt[i], 5'($urandom));
  endtask

  task automatic settle_idle();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_crc_enable(logic en);
    settle_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.crc_check_enable <= en;
    do @(posedge clk_i); while (!cfg_if.ready);
    chk_en = en;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_random(int unsigned n_items);
    int unsigned stop_at;
    int unsigned roll;
    logic [7:0]  b;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (pkt_held) begin
        // held packet: some dropped bytes and reads, then usually a release
        repeat ($urandom_range(0, 2)) send_item(OP_BYTE, noise_byte(), 5'($urandom));
        repeat ($urandom_range(0, 3)) send_item(OP_READ, 8'($urandom), pick_read_index());
        if (roll < 85) send_item(OP_RELEASE, 8'($urandom), 5'($urandom));
        else send_item(OP_UNUSED, 8'($urandom), 5'($urandom));
      end else if (roll < 60) begin
        send_frame($urandom_range(0, 5) == 0);
      end else if (roll < 70) begin
        repeat ($urandom_range(1, 6)) send_item(OP_BYTE, noise_byte(), 5'($urandom));
      end else if (roll < 78) begin
        b = 8'($urandom);
        if (b == HDR_SECOND) b = HDR_FIRST;
        send_item(OP_BYTE, HDR_FIRST, 5'($urandom));
        send_item(OP_BYTE, b, 5'($urandom));
      end else if (roll < 85) begin
        // cut-short packet; the next header lands inside its body
        send_item(OP_BYTE, HDR_FIRST, 5'($urandom));
        send_item(OP_BYTE, HDR_SECOND, 5'($urandom));
        repeat ($urandom_range(0, 12)) send_item(OP_BYTE, 8'($urandom), 5'($urandom));
      end else if (roll < 95) begin
        repeat ($urandom_range(1, 3)) send_item(OP_READ, 8'($urandom), pick_read_index());
      end else if (roll < 98) begin
        send_item(OP_RELEASE, 8'($urandom), 5'($urandom));
      end else begin
        send_item(OP_UNUSED, 8'($urandom), 5'($urandom));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_header_crc_packet_deframer: errors");
      $finish;
    end
  end

  // result side: stretches of full rate, random stalls, one long hold-off
  initial begin : result_ready_driver
    int unsigned span;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!long_hold_done && results_seen >= 400) begin
        long_hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        span = $urandom_range(10, 40);
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            out_if.ready <= 1'b1;
            repeat (span + 20) @(posedge clk_i);
          end
          9: begin
            out_if.ready <= 1'b0;
            repeat (span) @(posedge clk_i);
          end
          default: begin
            repeat (span) begin
              out_if.ready <= ($urandom_range(0, 3) != 0);
              @(posedge clk_i);
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    deframe_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer, status %0d", out_if.status));
      end else begin
        want = expected_results.pop_front();
        if (out_if.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_if.status, want.status));
        if (out_if.packet_ready !== want.pkt_ready)
          report_mismatch($sformatf("packet_ready %0b, want %0b", out_if.packet_ready,
                                    want.pkt_ready));
        if (out_if.byte_count !== want.count)
          report_mismatch($sformatf("byte_count %0d, want %0d", out_if.byte_count,
                                    want.count));
        if (out_if.read_value !== want.rdata)
          report_mismatch($sformatf("read_value 0x%02h, want 0x%02h", out_if.read_value,
                                    want.rdata));
      end
    end
  end

  initial begin : stimulus
    in_if.valid <= 1'b0;
    in_if.operation <= OP_BYTE;
    in_if.rx_byte <= '0;
    in_if.read_index <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.crc_check_enable <= 1'b1;

    chk_en = 1'b1;
    pkt_held = 1'b0;
    clear_hunt();
    foreach (pkt_mem[i]) begin
      pkt_mem[i] = '0;
      mem_valid[i] = 1'b0;
    end

    @(posedge rst_ni);
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_GOOD_PKT: send_frame(1'b0);
        ROW_BAD_PKT:  send_frame(1'b1);
        default: send_item(directed_rows[i].op, directed_rows[i].b, directed_rows[i].idx,
                           directed_rows[i].pinned, directed_rows[i].want);
      endcase
    end

    foreach (crc_plan[p]) begin
      write_crc_enable(crc_plan[p]);
      run_random(RANDOM_PER_SETTING);
    end

    settle_idle();
    if (mismatches == 0) begin
      $display("tb_header_crc_packet_deframer: clean");
    end else begin
      $display("tb_header_crc_packet_deframer: errors");
    end
    $finish;
  end

endmodule

@@ header_crc_packet_deframer.f @@
hw/rtl/hcd_pkg.sv
hw/rtl/hcd_in_if.sv
hw/rtl/hcd_out_if.sv
hw/rtl/hcd_cfg_if.sv
hw/rtl/hcd_ram.sv
hw/rtl/hcd_core.sv
hw/rtl/header_crc_packet_deframer.sv
hw/rtl/hcd_checker.sv
dv/tb_header_crc_packet_deframer.sv
